// ===== design/sfpds_pkg.sv =====
package sfpds_pkg;

  localparam int unsigned MaxPayloadDefault = 5;
  // payload bytes that feed the decoded position fields
  localparam int unsigned PosBytes = 5;

  localparam logic CfgHeaderByte = 1'b0;
  localparam logic CfgAcceptFn   = 1'b1;

  localparam logic [7:0] HeaderReset   = 8'hBB;
  localparam logic [7:0] AcceptFnReset = 8'h03;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhFunc    = 3'd1,
    PhLen     = 3'd2,
    PhPayload = 3'd3,
    PhCheck1  = 3'd4,
    PhCheck2  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    StPosOk   = 2'd0,
    StCkFail  = 2'd1,
    StOtherFn = 2'd2
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [7:0]         target_state;
  } result_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] accept_fn;
  } cfg_t;

endpackage

// ===== design/sfpds_parser.sv =====
module sfpds_parser #(
  parameter int unsigned MaxPayload = sfpds_pkg::MaxPayloadDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  sfpds_pkg::cfg_t   cfg_i,
  output logic              res_valid_o,
  output sfpds_pkg::result_t res_o
);
  import sfpds_pkg::*;

  // wide enough for a store position of length + 1
  localparam int unsigned PosW = $clog2(MaxPayload + 2);

  phase_e          phase_q, phase_d;
  logic [7:0]      fn_q, fn_d;
  logic [PosW-1:0] len_q, len_d;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      sos_q, sos_d;
  logic [7:0]      ck1_q, ck1_d;
  logic [7:0]      store_q [PosBytes];
  logic [7:0]      store_d [PosBytes];

  logic [7:0]      sum_add;
  logic [7:0]      sos_add;
  logic [PosW-1:0] cnt_inc;
  logic            wr_en;
  logic [PosW-1:0] wr_pos;

  assign sum_add = sum_q + byte_i;
  assign sos_add = sos_q + sum_add;
  assign cnt_inc = cnt_q + PosW'(1);

  always_comb begin
    phase_d     = PhIdle;
    fn_d        = fn_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    sos_d       = sos_q;
    ck1_d       = ck1_q;
    wr_en       = 1'b0;
    wr_pos      = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PhIdle: begin
        if (byte_i == cfg_i.header_byte) begin
          sum_d   = byte_i;
          sos_d   = byte_i;
          phase_d = PhFunc;
        end
      end
      PhFunc: begin
        fn_d    = byte_i;
        sum_d   = sum_add;
        sos_d   = sos_add;
        phase_d = PhLen;
      end
      PhLen: begin
        if (byte_i <= 8'(MaxPayload)) begin
          len_d   = byte_i[PosW-1:0];
          cnt_d   = '0;
          sum_d   = sum_add;
          sos_d   = sos_add;
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        // a zero-length frame drops back to idle here
        if (len_q != '0) begin
          wr_en   = 1'b1;
          wr_pos  = cnt_q;
          sum_d   = sum_add;
          sos_d   = sos_add;
          cnt_d   = cnt_inc;
          phase_d = PhPayload;
          if (cnt_inc >= len_q) begin
            cnt_d   = '0;
            phase_d = PhCheck1;
          end
        end
      end
      PhCheck1: begin
        ck1_d   = byte_i;
        wr_en   = 1'b1;
        wr_pos  = len_q;
        phase_d = PhCheck2;
      end
      PhCheck2: begin
        wr_en       = 1'b1;
        wr_pos      = len_q + PosW'(1);
        res_valid_o = 1'b1;
      end
      default: phase_d = PhIdle;
    endcase

    for (int i = 0; i < PosBytes; i++) begin
      store_d[i] = (wr_en && wr_pos == PosW'(i)) ? byte_i : store_q[i];
    end

    if (phase_q == PhCheck2) begin
      if (ck1_q != sum_q || byte_i != sos_q) begin
        res_o.status = StCkFail;
      end else if (fn_q == cfg_i.accept_fn) begin
        // decode from the store as it stands after the second check byte
        res_o.status       = StPosOk;
        res_o.offset_x     = {store_d[1], store_d[0]};
        res_o.offset_y     = {store_d[3], store_d[2]};
        res_o.target_state = store_d[4];
      end else begin
        res_o.status = StOtherFn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      fn_q    <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      sos_q   <= '0;
      ck1_q   <= '0;
      for (int i = 0; i < PosBytes; i++) begin
        store_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q <= phase_d;
      fn_q    <= fn_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      sos_q   <= sos_d;
      ck1_q   <= ck1_d;
      store_q <= store_d;
    end
  end

endmodule

// ===== design/serial_frame_parser_dual_sum.sv =====
// channel | direction | handshake             | payload
// rx      | in        | in_valid_i/in_ready_o | rx_byte_i
// result  | out       | out_valid_o/out_ready_i | frame_status_o, offset_x_o,
//         |           |                       | offset_y_o, target_state_o
// config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte per cycle while no held result stops it; a byte is registered, then parsed,
// so a result shows from the output register, which follows the byte register.
// the combinational running-sum update sets the rate.
// reset returns the parser to idle with header 0xbb and function id 0x03.
// the byte stage keeps moving while the result register is empty or drained;
// a held result stops it, and the input takes one more byte at most.
module serial_frame_parser_dual_sum #(
  parameter int unsigned MaxPayload = sfpds_pkg::MaxPayloadDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         frame_status_o,
  output logic signed [15:0] offset_x_o,
  output logic signed [15:0] offset_y_o,
  output logic [7:0]         target_state_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import sfpds_pkg::*;

  cfg_t    cfg_q;
  logic    byte_valid_q;
  logic [7:0] byte_q;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !byte_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= HeaderReset;
      cfg_q.accept_fn   <= AcceptFnReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHeaderByte: cfg_q.header_byte <= cfg_data_i;
        CfgAcceptFn:   cfg_q.accept_fn   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  sfpds_parser #(
    .MaxPayload(MaxPayload)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (byte_valid_q && advance),
    .byte_i     (byte_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= byte_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && byte_valid_q && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = out_q.status;
  assign offset_x_o     = out_q.offset_x;
  assign offset_y_o     = out_q.offset_y;
  assign target_state_o = out_q.target_state;

endmodule

// ===== design/sfpds_checker.sv =====
module sfpds_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         frame_status_o,
  input logic signed [15:0] offset_x_o,
  input logic signed [15:0] offset_y_o,
  input logic [7:0]         target_state_o
);
  import sfpds_pkg::*;

  // a held result keeps its value until the transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_status_o)
      && $stable(offset_x_o) && $stable(offset_y_o) && $stable(target_state_o))
    else $error("result changed while stalled");

  // only an accepted position frame carries position data
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o != StPosOk |->
      offset_x_o == '0 && offset_y_o == '0 && target_state_o == '0)
    else $error("position fields set on a non-position result");

  // a new result follows a byte taken at the input, through the byte and output registers
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input byte");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with the result side free");

endmodule

bind serial_frame_parser_dual_sum sfpds_checker u_sfpds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .frame_status_o(frame_status_o),
  .offset_x_o    (offset_x_o),
  .offset_y_o    (offset_y_o),
  .target_state_o(target_state_o)
);

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfpds_pkg::*;

  localparam int unsigned MAX_LEN = MaxPayloadDefault;
  localparam int unsigned CYCLE_LIMIT = 250000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         frame_status_o;
  logic signed [15:0] offset_x_o;
  logic signed [15:0] offset_y_o;
  logic [7:0]         target_state_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [7:0]         cfg_data_i;

  serial_frame_parser_dual_sum dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .offset_x_o     (offset_x_o),
    .offset_y_o     (offset_y_o),
    .target_state_o (target_state_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser copy kept by the testbench
  logic [7:0] hdr_cfg;
  logic [7:0] acc_cfg;
  phase_e     rx_phase;
  logic [7:0] fn_seen;
  logic [2:0] len_seen;
  logic [2:0] pay_idx;
  logic [7:0] sum_a;
  logic [7:0] sum_b;
  logic [7:0] check_a;
  logic [7:0] pay_mem [MAX_LEN];

  result_t     pending_frames [$];
  result_t     want;
  bit          allow_gaps;
  int unsigned bytes_in;
  int unsigned settings_used;
  int unsigned mismatches;
  int unsigned n_pos, n_ckfail, n_other;
  int unsigned cycles;

  function automatic void add_sums(logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic void keep_byte(int unsigned pos, logic [7:0] b);
    if (pos < MAX_LEN) pay_mem[pos] = b;
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    result_t r;
    if (rx_phase == PhIdle && b == hdr_cfg) begin
      sum_a = 8'h00;
      sum_b = 8'h00;
      add_sums(b);
      rx_phase = PhFunc;
    end else if (rx_phase == PhFunc) begin
      fn_seen = b;
      add_sums(b);
      rx_phase = PhLen;
    end else if (rx_phase == PhLen && b <= MAX_LEN) begin
      len_seen = b[2:0];
      pay_idx = 3'd0;
      add_sums(b);
      rx_phase = PhPayload;
    end else if (rx_phase == PhPayload && len_seen != 3'd0) begin
      keep_byte(pay_idx, b);
      add_sums(b);
      pay_idx = pay_idx + 3'd1;
      if (pay_idx >= len_seen) begin
        pay_idx = 3'd0;
        rx_phase = PhCheck1;
      end
    end else if (rx_phase == PhCheck1) begin
      check_a = b;
      keep_byte(len_seen, b);
      rx_phase = PhCheck2;
    end else if (rx_phase == PhCheck2) begin
      rx_phase = PhIdle;
      keep_byte(int'(len_seen) + 1, b);
      r = '0;
      if (check_a != sum_a || b != sum_b) begin
        r.status = StCkFail;
      end else if (fn_seen == acc_cfg) begin
        r.status = StPosOk;
        r.offset_x = {pay_mem[1], pay_mem[0]};
        r.offset_y = {pay_mem[3], pay_mem[2]};
        r.target_state = pay_mem[4];
      end else begin
        r.status = StOtherFn;
      end
      pending_frames.push_back(r);
    end else begin
      rx_phase = PhIdle;
    end
  endfunction

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(logic [7:0] b);
    while (allow_gaps && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_in++;
    parse_rx_byte(b);
  endtask

  // fault 1 spoils the first check byte, 2 the second; cut keeps only a prefix
  task automatic send_frame(logic [7:0] fn, logic [7:0] len, logic [39:0] pl,
                            int unsigned fault, int unsigned cut);
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] q [$];
    s1 = hdr_cfg;
    s2 = hdr_cfg;
    q = {hdr_cfg, fn, len};
    s1 = s1 + fn;
    s2 = s2 + s1;
    s1 = s1 + len;
    s2 = s2 + s1;
    if (len >= 1 && len <= MAX_LEN) begin
      for (int i = 0; i < len; i++) begin
        s1 = s1 + pl[8*i +: 8];
        s2 = s2 + s1;
        q.push_back(pl[8*i +: 8]);
      end
      if (fault == 1) s1 = s1 ^ 8'($urandom_range(1, 255));
      if (fault == 2) s2 = s2 ^ 8'($urandom_range(1, 255));
      q.push_back(s1);
      q.push_back(s2);
    end
    if (cut != 0 && cut < q.size()) q = q[0:cut-1];
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    // a byte that makes no result may still be in the pipe
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [7:0] hdr, logic [7:0] fn);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgHeaderByte;
    cfg_data_i  <= hdr;
    do @(posedge clk_i); while (!cfg_ready_o);
    hdr_cfg = hdr;
    cfg_index_i <= CfgAcceptFn;
    cfg_data_i  <= fn;
    do @(posedge clk_i); while (!cfg_ready_o);
    acc_cfg = fn;
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(int unsigned n);
    int unsigned start;
    int unsigned r;
    logic [7:0]  fn;
    start = bytes_in;
    while (bytes_in - start < n) begin
      r = $urandom_range(99);
      fn = $urandom_range(1) ? acc_cfg : 8'($urandom);
      if (r < 78) begin
        send_frame(fn, 8'($urandom_range(1, MAX_LEN)), 40'({$urandom, $urandom}),
                   ($urandom_range(99) < 15) ? $urandom_range(1, 2) : 0, 0);
      end else if (r < 82) begin
        send_frame(fn, 8'h00, '0, 0, 0);
      end else if (r < 87) begin
        send_frame(fn, 8'($urandom_range(MAX_LEN + 1, 255)), '0, 0, 0);
      end else if (r < 93) begin
        send_frame(fn, 8'($urandom_range(1, MAX_LEN)), 40'({$urandom, $urandom}),
                   0, $urandom_range(1, 5));
      end else begin
        send_byte(($urandom_range(3) == 0) ? hdr_cfg : 8'($urandom));
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00);
    // full frame at the offset extremes
    send_frame(AcceptFnReset, 8'd5, 40'hFF_7F_FF_80_00, 0, 0);
    // length byte equal to the header drops to idle and is not a new start
    send_frame(AcceptFnReset, HeaderReset, '0, 0, 0);
    // zero length: the following header byte only aborts the frame
    send_frame(AcceptFnReset, 8'h00, '0, 0, 0);
    send_byte(hdr_cfg);
    // short frame picks up its own check bytes and stale payload
    send_frame(AcceptFnReset, 8'd1, 40'h5A, 0, 0);
    send_frame(8'h07, 8'd1, 40'hA5, 2, 0);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    write_cfg(8'h00, 8'hFF);
    send_frame(8'hFF, 8'd5, '0, 0, 0);
    send_frame(8'h00, 8'd2, 40'h1234, 1, 0);
    send_frame(8'h03, 8'd3, 40'hC0FFEE, 0, 0);
    run_random(150);
    wait_drained();
    write_cfg(8'hFF, 8'h00);
    send_frame(8'h00, 8'd4, 40'h7F_FF_80_01, 0, 0);
    send_frame(8'hFF, 8'hFF, '0, 0, 0);
    run_random(150);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      // second setting is the long stretch without any idle cycles
      allow_gaps = (ph != 1);
      if (ph == 1) write_cfg(HeaderReset, AcceptFnReset);
      else write_cfg(8'($urandom), 8'($urandom));
      run_random(365);
    end
    allow_gaps = 1'b1;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !(allow_gaps && $urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame result: status %0d x %0d y %0d state %0d",
                   frame_status_o, offset_x_o, offset_y_o, target_state_o);
      end else begin
        want = pending_frames.pop_front();
        case (want.status)
          StPosOk:  n_pos++;
          StCkFail: n_ckfail++;
          default:  n_other++;
        endcase
        if (frame_status_o != want.status || offset_x_o != want.offset_x ||
            offset_y_o != want.offset_y || target_state_o != want.target_state) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"frame mismatch: expected status %0d x %0d y %0d state %0d,",
                      " got status %0d x %0d y %0d state %0d"},
                     want.status, want.offset_x, want.offset_y, want.target_state,
                     frame_status_o, offset_x_o, offset_y_o, target_state_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d frame results outstanding", pending_frames.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= 1'b0;
    cfg_data_i  <= 8'h00;
    cycles = 0;
    allow_gaps = 1'b1;
    hdr_cfg = HeaderReset;
    acc_cfg = AcceptFnReset;
    rx_phase = PhIdle;
    fn_seen = 8'h00;
    len_seen = 3'd0;
    pay_idx = 3'd0;
    sum_a = 8'h00;
    sum_b = 8'h00;
    check_a = 8'h00;
    foreach (pay_mem[i]) pay_mem[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    wait_drained();

    $display("sent %0d rx bytes under %0d register settings beyond reset",
             bytes_in, settings_used);
    $display("checked %0d position, %0d checksum-fail and %0d other-function frames",
             n_pos, n_ckfail, n_other);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_frames.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sfpds_pkg.sv
design/sfpds_parser.sv
design/serial_frame_parser_dual_sum.sv
design/sfpds_checker.sv
test/tb.sv
